/* rtl/bmc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bipartite guard counter package
// Shared sizes, operation codes and the word types of the block's channels.
// ----------------------------------------------------------------------------
package bmc_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int MAX_EDGES    = 1024;

  localparam int VERTEX_W = 8;
  localparam int COUNT_W  = $clog2(MAX_VERTICES) + 1;
  localparam int EDGE_AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EDGE_CW  = $clog2(MAX_EDGES + 1);

  localparam logic [COUNT_W-1:0] NV_MAX    = COUNT_W'(MAX_VERTICES);
  localparam logic [EDGE_CW-1:0] EDGE_FULL = EDGE_CW'(MAX_EDGES);

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_SOLVE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]          operation;
    logic [VERTEX_W-1:0] end_a;
    logic [VERTEX_W-1:0] end_b;
  } item_t;

  typedef struct packed {
    logic               possible;
    logic [COUNT_W-1:0] guard_total;
    logic               edges_dropped;
  } result_t;

  typedef struct packed {
    logic [EDGE_CW-1:0] total;
    logic               overflow;
  } edge_status_t;

endpackage

/* rtl/bmc_edge_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge store
// Holds the loaded edges in a memory with a fill count and an overflow flag.
// ----------------------------------------------------------------------------
module bmc_edge_store (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                add_en,
  input  logic                                clear_en,
  input  logic [2*bmc_pkg::VERTEX_W-1:0]      add_word,
  input  logic [bmc_pkg::EDGE_AW-1:0]         rd_addr,
  output bmc_pkg::edge_status_t               status,
  output logic [2*bmc_pkg::VERTEX_W-1:0]      rd_word
);

  logic [2*bmc_pkg::VERTEX_W-1:0] mem [bmc_pkg::MAX_EDGES];
  logic [bmc_pkg::EDGE_CW-1:0]    total;
  logic                           overflow;
  logic                           full;

  assign full = (total == bmc_pkg::EDGE_FULL);

  always_ff @(posedge clk) begin
    if (rst) begin
      total    <= '0;
      overflow <= 1'b0;
    end else if (clear_en) begin
      total    <= '0;
      overflow <= 1'b0;
    end else if (add_en) begin
      if (full) begin
        overflow <= 1'b1;
      end else begin
        total <= total + bmc_pkg::EDGE_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (add_en && !full) begin
      mem[total[bmc_pkg::EDGE_AW-1:0]] <= add_word;
    end
    rd_word <= mem[rd_addr];
  end

  assign status.total    = total;
  assign status.overflow = overflow;

endmodule

/* rtl/bmc_solver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-coloring sequencer
// Breadth-first search over the edge list with a color memory, a visit queue
// and one shared edge compare unit.
// ----------------------------------------------------------------------------
module bmc_solver (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [bmc_pkg::COUNT_W-1:0]       vertex_count,
  input  bmc_pkg::edge_status_t             edges,
  input  logic [2*bmc_pkg::VERTEX_W-1:0]    edge_word,
  input  logic                              done_ready,
  output logic [bmc_pkg::EDGE_AW-1:0]       edge_addr,
  output logic                              idle,
  output logic                              done_valid,
  output bmc_pkg::result_t                  done_result
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_INIT   = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_DEQ    = 4'd3;
  localparam logic [3:0] S_DEQW   = 4'd4;
  localparam logic [3:0] S_EFETCH = 4'd5;
  localparam logic [3:0] S_ECHECK = 4'd6;
  localparam logic [3:0] S_CREAD  = 4'd7;
  localparam logic [3:0] S_CCHECK = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  localparam int VW = bmc_pkg::VERTEX_W;
  localparam int CW = bmc_pkg::COUNT_W;
  localparam int NV = bmc_pkg::MAX_VERTICES;

  logic [3:0]                  state;
  logic [CW-1:0]               nv;
  logic [CW-1:0]               v;
  logic [NV-1:0]               vis;
  logic [CW-1:0]               head;
  logic [CW-1:0]               tail;
  logic [VW-1:0]               cur;
  logic                        cur_col;
  logic [CW-1:0]               members;
  logic [CW-1:0]               first;
  logic [bmc_pkg::EDGE_CW-1:0] e;
  logic [VW-1:0]               other;
  logic [CW-1:0]               sum;
  logic                        ok;

  logic                        cmem [NV];
  logic                        col_q;
  logic [VW:0]                 qmem [NV];
  logic [VW:0]                 q_q;

  logic [VW-1:0]               ea;
  logic [VW-1:0]               eb;
  logic                        in_range;
  logic                        hit_a;
  logic                        hit_b;
  logic [VW-1:0]               nbr;
  logic                        relevant;
  logic [bmc_pkg::EDGE_CW-1:0] e_plus;
  logic                        last_edge;
  logic [CW-1:0]               second;
  logic [CW-1:0]               comp_guard;
  logic                        comp_start;
  logic                        new_nbr;

  logic                        cw_en;
  logic [VW-1:0]               cw_addr;
  logic                        cw_data;
  logic                        qw_en;
  logic [VW-1:0]               qw_addr;
  logic [VW:0]                 qw_data;

  assign ea       = edge_word[VW-1:0];
  assign eb       = edge_word[2*VW-1:VW];
  assign in_range = ({1'b0, ea} < nv) && ({1'b0, eb} < nv);
  assign hit_a    = (ea == cur);
  assign hit_b    = (eb == cur);
  assign nbr      = hit_a ? eb : ea;
  assign relevant = in_range && (hit_a || hit_b);
  assign new_nbr  = (state == S_ECHECK) && relevant && !vis[nbr];

  assign e_plus    = e + bmc_pkg::EDGE_CW'(1);
  assign last_edge = (e_plus == edges.total);

  assign comp_start = (state == S_SCAN) && (v != nv) && !vis[v[VW-1:0]];

  always_comb begin
    second = members - first;
    if (members == CW'(1)) begin
      comp_guard = CW'(1);
    end else if ((first != '0) && (second != '0)) begin
      comp_guard = (first < second) ? first : second;
    end else begin
      comp_guard = (first > second) ? first : second;
    end
  end

  always_comb begin
    cw_en   = 1'b0;
    cw_addr = v[VW-1:0];
    cw_data = 1'b0;
    qw_en   = 1'b0;
    qw_addr = '0;
    qw_data = {v[VW-1:0], 1'b0};
    if (comp_start) begin
      cw_en = 1'b1;
      qw_en = 1'b1;
    end else if (new_nbr) begin
      cw_en   = 1'b1;
      cw_addr = nbr;
      cw_data = ~cur_col;
      qw_en   = 1'b1;
      qw_addr = tail[VW-1:0];
      qw_data = {nbr, ~cur_col};
    end
  end

  always_ff @(posedge clk) begin
    if (cw_en) begin
      cmem[cw_addr] <= cw_data;
    end
    col_q <= cmem[other];
    if (qw_en) begin
      qmem[qw_addr] <= qw_data;
    end
    q_q <= qmem[head[VW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      vis   <= '0;
      ok    <= 1'b1;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            nv    <= (vertex_count > bmc_pkg::NV_MAX) ? bmc_pkg::NV_MAX : vertex_count;
            state <= S_INIT;
          end
        end
        S_INIT: begin
          vis   <= '0;
          v     <= '0;
          sum   <= '0;
          ok    <= 1'b1;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (v == nv) begin
            state <= S_DONE;
          end else if (vis[v[VW-1:0]]) begin
            v <= v + CW'(1);
          end else begin
            vis[v[VW-1:0]] <= 1'b1;
            head           <= '0;
            tail           <= CW'(1);
            members        <= '0;
            first          <= '0;
            state          <= S_DEQ;
          end
        end
        S_DEQ: begin
          if (head == tail) begin
            sum   <= sum + comp_guard;
            v     <= v + CW'(1);
            state <= S_SCAN;
          end else begin
            state <= S_DEQW;
          end
        end
        S_DEQW: begin
          cur     <= q_q[VW:1];
          cur_col <= q_q[0];
          members <= members + CW'(1);
          first   <= first + CW'(!q_q[0]);
          head    <= head + CW'(1);
          e       <= '0;
          state   <= (edges.total == '0) ? S_DEQ : S_EFETCH;
        end
        S_EFETCH: begin
          state <= S_ECHECK;
        end
        S_ECHECK: begin
          if (relevant && vis[nbr]) begin
            other <= nbr;
            state <= S_CREAD;
          end else begin
            if (new_nbr) begin
              vis[nbr] <= 1'b1;
              tail     <= tail + CW'(1);
            end
            e     <= e_plus;
            state <= last_edge ? S_DEQ : S_EFETCH;
          end
        end
        S_CREAD: begin
          state <= S_CCHECK;
        end
        S_CCHECK: begin
          if (col_q == cur_col) begin
            ok    <= 1'b0;
            state <= S_DONE;
          end else begin
            e     <= e_plus;
            state <= last_edge ? S_DEQ : S_EFETCH;
          end
        end
        S_DONE: begin
          if (done_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign edge_addr                 = e[bmc_pkg::EDGE_AW-1:0];
  assign idle                      = (state == S_IDLE);
  assign done_valid                = (state == S_DONE);
  assign done_result.possible      = ok;
  assign done_result.guard_total   = ok ? sum : '0;
  assign done_result.edges_dropped = edges.overflow;

  a_queue_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEQ || state == S_DEQW) |-> (head <= tail && tail <= nv))
    else $error("visit queue head passed tail or queue overgrew");

  a_vis_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == S_INIT) |=> (vis == '0))
    else $error("visited flags not cleared at solve start");

  a_fetch_latency: assert property (@(posedge clk) disable iff (rst)
    (state == S_ECHECK) |-> ($past(state) == S_EFETCH))
    else $error("edge checked without a fetch cycle");

  a_total_zero: assert property (@(posedge clk) disable iff (rst)
    done_valid |-> (done_result.possible || done_result.guard_total == '0))
    else $error("nonzero total reported for an impossible graph");

endmodule

/* rtl/bipartite_min_cover_counter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bipartite minimum guard counter
// Edge loading, two-coloring solve and result register around the sequencer.
// ----------------------------------------------------------------------------
// Add and clear words are taken only while the sequencer is idle and leave it
// idle. A solve word occupies the block until its result is loaded into the
// output register: the sequencer scans the vertices, and for every vertex it
// takes from the visit queue it walks the whole edge list through the single
// edge memory read port, fetching and checking one edge at a time, with a
// color memory read and check for an edge that reaches an already colored
// vertex. A finished result waits in the output register while add and clear
// words are taken.
// ----------------------------------------------------------------------------
module bipartite_min_cover_counter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  bmc_pkg::item_t                item_data,
  output logic                          result_valid,
  input  logic                          result_ready,
  output bmc_pkg::result_t              result_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bmc_pkg::COUNT_W-1:0]   cfg_data
);

  logic [bmc_pkg::COUNT_W-1:0]        vertex_count;
  logic                               item_fire;
  logic                               add_en;
  logic                               clear_en;
  logic                               start;
  bmc_pkg::edge_status_t              edges;
  logic [2*bmc_pkg::VERTEX_W-1:0]     edge_word;
  logic [bmc_pkg::EDGE_AW-1:0]        edge_addr;
  logic                               idle;
  logic                               done_valid;
  logic                               done_ready;
  bmc_pkg::result_t                   done_result;

  assign cfg_ready  = 1'b1;
  assign item_ready = idle;
  assign item_fire  = item_valid && item_ready;
  assign add_en     = item_fire && (item_data.operation == bmc_pkg::OP_ADD);
  assign clear_en   = item_fire && (item_data.operation == bmc_pkg::OP_CLEAR);
  assign start      = item_fire && (item_data.operation == bmc_pkg::OP_SOLVE);
  assign done_ready = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      vertex_count <= cfg_data;
    end
  end

  bmc_edge_store u_store (
    .clk      (clk),
    .rst      (rst),
    .add_en   (add_en),
    .clear_en (clear_en),
    .add_word ({item_data.end_b, item_data.end_a}),
    .rd_addr  (edge_addr),
    .status   (edges),
    .rd_word  (edge_word)
  );

  bmc_solver u_solver (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .vertex_count (vertex_count),
    .edges        (edges),
    .edge_word    (edge_word),
    .done_ready   (done_ready),
    .edge_addr    (edge_addr),
    .idle         (idle),
    .done_valid   (done_valid),
    .done_result  (done_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (done_valid && done_ready) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_valid && done_ready) begin
      result_data <= done_result;
    end
  end

endmodule

/* tb/tb_bipartite_min_cover_counter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bipartite minimum guard counter testbench
// Drives edge, solve and clear words with random gaps on both channels, and
// rewrites the vertex count between phases while the block is idle. A
// scoreboard class keeps its own copy of the edge store and two-colors the
// graph on every solve, so that each result word is checked field by field
// against the oldest solve still waiting. One phase fills the edge store past
// capacity, and the receiver holds off for a long stretch now and then.
// ----------------------------------------------------------------------------

class guard_scoreboard;
  logic [15:0]      edge_mem [$];
  bit               dropped;
  int unsigned      vcount;
  bmc_pkg::result_t expected_q [$];
  int               errors;

  function new();
    dropped = 0;
    vcount  = 0;
    errors  = 0;
  endfunction

  function void set_count(logic [bmc_pkg::COUNT_W-1:0] v);
    vcount = v;
  endfunction

  function int unsigned stored_edges();
    return edge_mem.size();
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  function bmc_pkg::result_t solve_graph();
    logic [1:0]       color [bmc_pkg::MAX_VERTICES];
    int unsigned      order [bmc_pkg::MAX_VERTICES];
    int unsigned      nv, head, tail, members, first, second, cur, other, sum;
    int unsigned      a, b;
    logic [15:0]      w;
    bit               ok, touches;
    bmc_pkg::result_t r;
    nv  = (vcount < bmc_pkg::MAX_VERTICES) ? vcount : bmc_pkg::MAX_VERTICES;
    sum = 0;
    ok  = 1;
    foreach (color[i]) color[i] = 2'd0;
    for (int v = 0; v < nv && ok; v++) begin
      if (color[v] == 2'd0) begin
        head     = 0;
        tail     = 1;
        members  = 0;
        first    = 0;
        order[0] = v;
        color[v] = 2'd1;
        while (head < tail && ok) begin
          cur  = order[head];
          head = head + 1;
          members = members + 1;
          if (color[cur] == 2'd1) first = first + 1;
          for (int e = 0; e < edge_mem.size() && ok; e++) begin
            w = edge_mem[e];
            a = w[7:0];
            b = w[15:8];
            touches = 0;
            if (a < nv && b < nv) begin
              if (a == cur) begin
                other   = b;
                touches = 1;
              end else if (b == cur) begin
                other   = a;
                touches = 1;
              end
            end
            if (touches) begin
              if (color[other] == 2'd0) begin
                color[other] = 2'(3 - color[cur]);
                if (tail < bmc_pkg::MAX_VERTICES) begin
                  order[tail] = other;
                  tail = tail + 1;
                end
              end else if (color[other] == color[cur]) begin
                ok = 0;
              end
            end
          end
        end
        if (ok) begin
          second = members - first;
          if (members == 1) sum = sum + 1;
          else if (first > 0 && second > 0) sum = sum + ((first < second) ? first : second);
          else sum = sum + ((first > second) ? first : second);
        end
      end
    end
    r.possible      = ok;
    r.guard_total   = ok ? bmc_pkg::COUNT_W'(sum) : '0;
    r.edges_dropped = dropped;
    return r;
  endfunction

  function void note_item(bmc_pkg::item_t it);
    case (it.operation)
      bmc_pkg::OP_ADD: begin
        if (edge_mem.size() < bmc_pkg::MAX_EDGES)
          edge_mem.insert(edge_mem.size(), {it.end_b, it.end_a});
        else dropped = 1;
      end
      bmc_pkg::OP_CLEAR: begin
        edge_mem.delete();
        dropped = 0;
      end
      bmc_pkg::OP_SOLVE: begin
        expected_q.insert(expected_q.size(), solve_graph());
      end
      default: begin
      end
    endcase
  endfunction

  function void check_result(bmc_pkg::result_t got);
    bmc_pkg::result_t want;
    if (expected_q.size() == 0) begin
      $error("unexpected result word: possible %0d guard_total %0d edges_dropped %0d",
             got.possible, got.guard_total, got.edges_dropped);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    if (got.possible !== want.possible) begin
      $error("possible: expected %0d, actual %0d", want.possible, got.possible);
      errors++;
    end
    if (got.guard_total !== want.guard_total) begin
      $error("guard_total: expected %0d, actual %0d", want.guard_total, got.guard_total);
      errors++;
    end
    if (got.edges_dropped !== want.edges_dropped) begin
      $error("edges_dropped: expected %0d, actual %0d", want.edges_dropped, got.edges_dropped);
      errors++;
    end
  endfunction
endclass

module tb_bipartite_min_cover_counter;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic                          clk;
  logic                          rst;
  logic                          item_valid;
  logic                          item_ready;
  bmc_pkg::item_t                item_data;
  logic                          result_valid;
  logic                          result_ready;
  bmc_pkg::result_t              result_data;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [bmc_pkg::COUNT_W-1:0]   cfg_data;

  guard_scoreboard sb = new();

  int          idle_pct = 28;
  bit          hold_request = 0;
  int unsigned items_sent = 0;
  bit          side [bmc_pkg::MAX_VERTICES];

  bipartite_min_cover_counter dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item_data    (item_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #25_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic bmc_pkg::item_t make_item(logic [1:0] op, logic [7:0] a, logic [7:0] b);
    bmc_pkg::item_t it;
    it.operation = op;
    it.end_a     = a;
    it.end_b     = b;
    return it;
  endfunction

  function automatic bmc_pkg::item_t make_edge(int unsigned nv, bit split);
    bmc_pkg::item_t it;
    int unsigned    span;
    int             tries;
    span = (nv == 0) ? 1 : ((nv > bmc_pkg::MAX_VERTICES) ? bmc_pkg::MAX_VERTICES : nv);
    it.operation = bmc_pkg::OP_ADD;
    it.end_a = 8'($urandom_range(span - 1));
    it.end_b = 8'($urandom_range(span - 1));
    tries = 0;
    while (split && side[it.end_a] == side[it.end_b] && tries < 8) begin
      it.end_b = 8'($urandom_range(span - 1));
      tries++;
    end
    if (!split && $urandom_range(19) == 0) it.end_b = it.end_a;
    if ($urandom_range(15) == 0) it.end_a = rand_byte();
    if ($urandom_range(15) == 0) it.end_b = rand_byte();
    return it;
  endfunction

  task automatic send_item(input bmc_pkg::item_t it);
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item_data  <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sb.note_item(it);
    if (it.operation != OP_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  task automatic write_count(input logic [bmc_pkg::COUNT_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_count(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Adds and clears give no result word, so the task also waits on past the
  // last result before the block counts as idle.
  task automatic settle();
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic random_phase(input bit pressure);
    int unsigned nv, adds, rounds, pick, cap;
    bit          split, wide;
    pick = $urandom_range(99);
    wide = 0;
    cap  = 20;
    if (pick < 8) begin
      nv = $urandom_range(1);
    end else if (pick < 70) begin
      nv = $urandom_range(2, 12);
    end else if (pick < 85) begin
      nv   = $urandom_range(13, 40);
      wide = 1;
      cap  = 16;
    end else begin
      case ($urandom_range(2))
        0: nv = bmc_pkg::MAX_VERTICES;
        1: nv = 511;
        default: nv = $urandom_range(200, 511);
      endcase
      wide = 1;
      cap  = 6;
    end
    write_count(bmc_pkg::COUNT_W'(nv));
    if (wide || sb.stored_edges() > 40 || $urandom_range(3) == 0)
      send_item(make_item(bmc_pkg::OP_CLEAR, rand_byte(), rand_byte()));
    split = 1'($urandom_range(1));
    foreach (side[i]) side[i] = 1'($urandom_range(1));
    rounds = pressure ? 4 : (($urandom_range(9) < 3) ? 2 : 1);
    for (int r = 0; r < rounds; r++) begin
      if (r > 0 && $urandom_range(9) == 0)
        send_item(make_item(bmc_pkg::OP_CLEAR, rand_byte(), rand_byte()));
      adds = (r == 0) ? $urandom_range(1, cap) : $urandom_range(0, 4);
      repeat (adds) begin
        if ($urandom_range(24) == 0)
          send_item(make_item(OP_UNUSED, rand_byte(), rand_byte()));
        send_item(make_edge(nv, split));
      end
      send_item(make_item(bmc_pkg::OP_SOLVE, rand_byte(), rand_byte()));
    end
  endtask

  // The receiver holds off for a long stretch whenever a hold is requested.
  initial begin
    int hold_left;
    hold_left    = 0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        result_ready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 0;
        hold_left    = 400;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_result(result_data);
  end

  initial begin
    int phase;
    rst          = 1'b1;
    item_valid   = 1'b0;
    item_data    = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_item(make_item(bmc_pkg::OP_SOLVE, 8'd0, 8'd0));
    settle();
    write_count(bmc_pkg::COUNT_W'(4));
    send_item(make_item(bmc_pkg::OP_ADD, 8'd0, 8'd1));
    send_item(make_item(bmc_pkg::OP_ADD, 8'd2, 8'd3));
    send_item(make_item(bmc_pkg::OP_SOLVE, 8'd0, 8'd0));
    send_item(make_item(bmc_pkg::OP_ADD, 8'd1, 8'd2));
    send_item(make_item(bmc_pkg::OP_ADD, 8'd3, 8'd0));
    send_item(make_item(bmc_pkg::OP_SOLVE, 8'd255, 8'd255));
    send_item(make_item(bmc_pkg::OP_ADD, 8'd0, 8'd2));
    send_item(make_item(bmc_pkg::OP_SOLVE, 8'd0, 8'd0));
    send_item(make_item(bmc_pkg::OP_CLEAR, 8'd0, 8'd0));
    send_item(make_item(bmc_pkg::OP_ADD, 8'd3, 8'd3));
    send_item(make_item(bmc_pkg::OP_SOLVE, 8'd0, 8'd0));
    send_item(make_item(bmc_pkg::OP_CLEAR, 8'd255, 8'd255));
    send_item(make_item(bmc_pkg::OP_ADD, 8'd255, 8'd0));
    send_item(make_item(bmc_pkg::OP_ADD, 8'd7, 8'd9));
    send_item(make_item(bmc_pkg::OP_SOLVE, 8'd0, 8'd0));
    send_item(make_item(OP_UNUSED, 8'd255, 8'd255));
    settle();
    write_count(bmc_pkg::COUNT_W'(511));
    send_item(make_item(bmc_pkg::OP_CLEAR, 8'd0, 8'd0));
    send_item(make_item(bmc_pkg::OP_ADD, 8'd0, 8'd255));
    send_item(make_item(bmc_pkg::OP_ADD, 8'd255, 8'd254));
    send_item(make_item(bmc_pkg::OP_SOLVE, 8'd0, 8'd0));
    settle();
    write_count(bmc_pkg::COUNT_W'(bmc_pkg::MAX_VERTICES));
    send_item(make_item(bmc_pkg::OP_SOLVE, 8'd0, 8'd0));

    phase = 0;
    while (items_sent < 1250) begin
      settle();
      idle_pct = (phase >= 6 && phase < 10) ? 0 : 28;
      if (phase == 3 || phase == 25) hold_request = 1;
      if (phase == 12) begin
        // Fill the edge store past capacity with few vertices to keep the solve short.
        write_count(bmc_pkg::COUNT_W'($urandom_range(3)));
        send_item(make_item(bmc_pkg::OP_CLEAR, 8'd0, 8'd0));
        repeat (bmc_pkg::MAX_EDGES + 6)
          send_item(make_edge($urandom_range(1) ? 4 : bmc_pkg::MAX_VERTICES, 0));
        send_item(make_item(bmc_pkg::OP_SOLVE, 8'd0, 8'd0));
        send_item(make_item(bmc_pkg::OP_CLEAR, 8'd0, 8'd0));
        send_item(make_item(bmc_pkg::OP_SOLVE, 8'd0, 8'd0));
      end else begin
        random_phase(phase == 3 || phase == 25);
      end
      phase++;
    end

    settle();
    repeat (24) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/bmc_pkg.sv
rtl/bmc_edge_store.sv
rtl/bmc_solver.sv
rtl/bipartite_min_cover_counter.sv
tb/tb_bipartite_min_cover_counter.sv
